// ===== rtl/core/charge_current_plateau_detector_unit_defines.svh =====
// Assertion macros shared by the plateau detector RTL.
`ifndef CHARGE_CURRENT_PLATEAU_DETECTOR_UNIT_DEFINES_SVH
`define CHARGE_CURRENT_PLATEAU_DETECTOR_UNIT_DEFINES_SVH

`ifndef SYNTH

// Same-cycle implication, checked outside reset.
`define CCPD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ccpd assertion failed: same-cycle implication");

// Next-cycle implication, checked outside reset.
`define CCPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ccpd assertion failed: next-cycle implication");

`else

`define CCPD_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define CCPD_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/core/ccpd_pkg.sv =====
// Shared constants for the charge current plateau detector.
package ccpd_pkg;

    // parameter defaults
    localparam int DEF_FILTER_SHIFT = 8;
    localparam int DEF_SAMPLE_WIDTH = 24;
    localparam int DEF_COUNT_WIDTH  = 16;

    // fixed field widths
    localparam int CLAMP_W   = 15;
    localparam int WIN_W     = 10;
    localparam int HOLD_W    = 16;
    localparam int VOLT_W    = 16;
    localparam int SLOPE_W   = 16;
    localparam int SETTLED_W = 16;

    // configuration port
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_ADDR_W-1:0] REG_CLAMP_LIMIT   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_SETTLE_WINDOW = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_HOLD_COUNT    = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_FULL_VOLTAGE  = 2'd3;

    localparam logic [CLAMP_W-1:0] RST_CLAMP_LIMIT   = 15'd2000;
    localparam logic [WIN_W-1:0]   RST_SETTLE_WINDOW = 10'd5;
    localparam logic [HOLD_W-1:0]  RST_HOLD_COUNT    = 16'd1200;
    localparam logic [VOLT_W-1:0]  RST_FULL_VOLTAGE  = 16'd28800;

    // operation codes carried on tuser
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

endpackage

// ===== rtl/core/charge_current_plateau_detector_unit.sv =====
// Charge current plateau detector: slope filter, settle counter and full-charge flag.
// Output: a result appears on the master side the cycle after its input transfer.
// Throughput: one item per cycle when not stalled; the whole step is one combinational
//   pass from the state registers and the input beat into the state and result registers.
// Back-pressure: the result register frees as it is taken, so a new transfer is
//   accepted in the same cycle the previous result leaves.
// Reset (i_rst_n low, synchronous): filter state and counter clear, registers load defaults.
`include "charge_current_plateau_detector_unit_defines.svh"

module charge_current_plateau_detector_unit
    import ccpd_pkg::*;
#(
    parameter int FILTER_SHIFT = DEF_FILTER_SHIFT,
    parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
    parameter int COUNT_WIDTH  = DEF_COUNT_WIDTH,
    localparam int IN_TDATA_W  = ((SAMPLE_WIDTH + VOLT_W + 7) / 8) * 8,
    localparam int OUT_TDATA_W = ((1 + SLOPE_W + SETTLED_W + 7) / 8) * 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,

    // sample stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // current_sample, voltage_mv, zero pad
    input  logic [0:0]             s_axis_tuser,   // operation

    // result stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // full_charge, filtered_slope,
                                                   // settled_count, zero pad

    // configuration writes
    input  logic                   i_cfg_we,
    input  logic [CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0]  i_cfg_wdata
);

    // Accumulator settles near (2^FILTER_SHIFT - 1) * clamp, plus sign and margin.
    localparam int ACC_W  = CLAMP_W + FILTER_SHIFT + 2;
    localparam int SUM_W  = ACC_W + 1;
    localparam int DIFF_W = SAMPLE_WIDTH + 1;
    localparam int CLP_W  = CLAMP_W + 1;          // clamped difference, signed
    localparam int CNT_XW = (COUNT_WIDTH > SETTLED_W) ? COUNT_WIDTH : SETTLED_W;
    localparam int PAD_W  = OUT_TDATA_W - (1 + SLOPE_W + SETTLED_W);

    // configuration registers
    logic [CLAMP_W-1:0] r_clamp_limit;
    logic [WIN_W-1:0]   r_settle_window;
    logic [HOLD_W-1:0]  r_hold_count;
    logic [VOLT_W-1:0]  r_full_voltage;

    // detector state
    logic signed [SAMPLE_WIDTH-1:0] r_prev, n_prev;
    logic signed [ACC_W-1:0]        r_acc,  n_acc;
    logic [COUNT_WIDTH-1:0]         r_cnt,  n_cnt;

    // result register
    logic                    r_out_valid;
    logic [OUT_TDATA_W-1:0]  r_out_data, n_out_data;

    logic in_xfer;
    logic is_clear;

    logic signed [SAMPLE_WIDTH-1:0] cur;
    logic [VOLT_W-1:0]              volt;
    logic signed [DIFF_W-1:0]       diff, lim_pos, lim_neg;
    logic signed [CLP_W-1:0]        diff_clp;
    logic signed [SUM_W-1:0]        sum, slope_full, slope_mag;
    logic                           settled;
    logic [CNT_XW-1:0]              cnt_x;
    logic                           full;

    // A free result slot lets the next transfer in, even while the old one drains.
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign is_clear      = (s_axis_tuser[0] == OP_CLEAR);

    assign cur  = $signed(s_axis_tdata[SAMPLE_WIDTH-1:0]);
    assign volt = s_axis_tdata[SAMPLE_WIDTH +: VOLT_W];

    always_comb begin
        // first difference against the stored sample
        diff    = DIFF_W'(cur) - DIFF_W'(r_prev);
        lim_pos = $signed(DIFF_W'({1'b0, r_clamp_limit}));
        lim_neg = -lim_pos;

        // limit to +/- clamp_limit; the result always fits CLP_W bits
        priority if (diff > lim_pos) begin
            diff_clp = CLP_W'(lim_pos);
        end else if (diff < lim_neg) begin
            diff_clp = CLP_W'(lim_neg);
        end else begin
            diff_clp = CLP_W'(diff);
        end

        // leaky filter: floor shift, state keeps the remainder of the leak
        sum        = SUM_W'(diff_clp) + SUM_W'(r_acc);
        slope_full = sum >>> FILTER_SHIFT;
        slope_mag  = slope_full[SUM_W-1] ? -slope_full : slope_full;
        settled    = (slope_mag <= $signed(SUM_W'({1'b0, r_settle_window})));

        // default: hold state
        n_prev = r_prev;
        n_acc  = r_acc;
        n_cnt  = r_cnt;

        if (is_clear) begin
            n_prev = '0;
            n_acc  = '0;
            n_cnt  = '0;
        end else begin
            n_prev = cur;
            n_acc  = ACC_W'(sum - slope_full);
            if (!settled) begin
                n_cnt = '0;
            end else if (r_cnt != {COUNT_WIDTH{1'b1}}) begin
                n_cnt = r_cnt + 1'b1;      // saturate at all ones
            end
        end

        cnt_x = CNT_XW'(n_cnt);
        full  = !is_clear && (volt >= r_full_voltage) && (cnt_x > CNT_XW'(r_hold_count));

        if (is_clear) begin
            n_out_data = '0;
        end else begin
            n_out_data = {{PAD_W{1'b0}}, cnt_x[SETTLED_W-1:0],
                          slope_full[SLOPE_W-1:0], full};
        end
    end

    // configuration port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clamp_limit   <= RST_CLAMP_LIMIT;
            r_settle_window <= RST_SETTLE_WINDOW;
            r_hold_count    <= RST_HOLD_COUNT;
            r_full_voltage  <= RST_FULL_VOLTAGE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_CLAMP_LIMIT:   r_clamp_limit   <= i_cfg_wdata[CLAMP_W-1:0];
                REG_SETTLE_WINDOW: r_settle_window <= i_cfg_wdata[WIN_W-1:0];
                REG_HOLD_COUNT:    r_hold_count    <= i_cfg_wdata[HOLD_W-1:0];
                REG_FULL_VOLTAGE:  r_full_voltage  <= i_cfg_wdata[VOLT_W-1:0];
            endcase
        end
    end

    // detector state, advanced once per input transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
            r_acc  <= '0;
            r_cnt  <= '0;
        end else if (in_xfer) begin
            r_prev <= n_prev;
            r_acc  <= n_acc;
            r_cnt  <= n_cnt;
        end
    end

    // result slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_xfer) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_out_data <= n_out_data;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // checks
    `CCPD_ASSERT_NEXT(a_clear_zeroes_state, i_clk, i_rst_n, in_xfer && is_clear, (r_prev == '0) && (r_acc == '0) && (r_cnt == '0))
    `CCPD_ASSERT_NEXT(a_clear_zeroes_result, i_clk, i_rst_n, in_xfer && is_clear, m_axis_tvalid && (m_axis_tdata == '0))
    `CCPD_ASSERT_IMPL(a_ready_when_slot_free, i_clk, i_rst_n, !m_axis_tvalid, s_axis_tready)
    `CCPD_ASSERT_IMPL(a_full_needs_count, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[0], r_cnt != '0)

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for the charge current plateau detector unit.
`timescale 1ns / 100ps

module tb;
    import ccpd_pkg::*;

    localparam int IN_W  = ((DEF_SAMPLE_WIDTH + VOLT_W + 7) / 8) * 8;
    localparam int OUT_W = ((1 + SLOPE_W + SETTLED_W + 7) / 8) * 8;
    localparam int CNT_MAX = (1 << DEF_COUNT_WIDTH) - 1;

    // result word as it sits on m_axis_tdata, lowest field last
    typedef struct packed {
        logic [SETTLED_W-1:0] settled;
        logic [SLOPE_W-1:0]   slope;
        logic                 full;
    } t_plateau_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_W-1:0]       s_axis_tdata = '0;    // current_sample, voltage_mv
    logic [0:0]            s_axis_tuser = OP_SAMPLE; // operation
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_W-1:0]      m_axis_tdata;         // full_charge, filtered_slope,
                                                 // settled_count, zero pad
    logic                  i_cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr = REG_CLAMP_LIMIT;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;

    // idle odds in percent per cycle for each side of the stream
    int unsigned src_idle_pct  = 17;
    int unsigned sink_idle_pct = 57;
    int unsigned fail_count    = 0;

    // shadow of the register file
    logic [CLAMP_W-1:0] cfg_clamp  = RST_CLAMP_LIMIT;
    logic [WIN_W-1:0]   cfg_window = RST_SETTLE_WINDOW;
    logic [HOLD_W-1:0]  cfg_hold   = RST_HOLD_COUNT;
    logic [VOLT_W-1:0]  cfg_fullv  = RST_FULL_VOLTAGE;

    // shadow of the detector state
    longint      prev_current = 0;
    longint      filt_acc     = 0;
    int unsigned settle_cnt   = 0;

    t_plateau_result plateau_expect_q[$];

    charge_current_plateau_detector_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // hard stop well beyond the slowest legal run
    initial begin
        #500_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // One step of the detector: differentiate, clamp, leaky filter,
    // settle counter, full-charge decision; a clear zeroes the state.
    function automatic t_plateau_result predict_plateau(logic op, logic [23:0] cur_bits,
                                                        logic [15:0] volt);
        t_plateau_result r;
        longint cur, diff, lim, sum, slope, mag;
        r = '0;
        if (op == OP_CLEAR) begin
            prev_current = 0;
            filt_acc     = 0;
            settle_cnt   = 0;
            return r;
        end
        cur  = $signed(cur_bits);
        diff = cur - prev_current;
        prev_current = cur;
        lim = longint'(cfg_clamp);
        if (diff > lim)
            diff = lim;
        else if (diff < -lim)
            diff = -lim;
        sum   = diff + filt_acc;
        slope = sum >>> DEF_FILTER_SHIFT;   // floor division
        filt_acc = sum - slope;
        mag = (slope < 0) ? -slope : slope;
        if (mag <= longint'(cfg_window)) begin
            if (settle_cnt < CNT_MAX)
                settle_cnt++;
        end else begin
            settle_cnt = 0;
        end
        r.full    = (volt >= cfg_fullv) && (settle_cnt > cfg_hold);
        r.slope   = slope[15:0];
        r.settled = settle_cnt[15:0];
        return r;
    endfunction

    task automatic note_mismatch(string what, longint want_v, longint got_v);
        fail_count++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want_v, got_v);
    endtask

    // Receiver back-pressure: one draw per cycle.
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // Every result transfer is matched against the oldest prediction.
    always @(posedge i_clk) begin : result_check
        t_plateau_result want, got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_plateau_result'(m_axis_tdata[32:0]);
            if (plateau_expect_q.size() == 0) begin
                fail_count++;
                $display("%0t: result with nothing expected, expected none, actual %h",
                         $time, m_axis_tdata);
            end else begin
                want = plateau_expect_q.pop_front();
                if (got.full != want.full)
                    note_mismatch("full_charge", want.full, got.full);
                if (got.slope != want.slope)
                    note_mismatch("filtered_slope", $signed(want.slope), $signed(got.slope));
                if (got.settled != want.settled)
                    note_mismatch("settled_count", want.settled, got.settled);
            end
        end
    end

    // One input transfer; the prediction is queued on the accepting edge.
    // tvalid stays high afterwards so back-to-back items need no extra edge.
    task automatic send_item(logic op, logic [23:0] cur, logic [15:0] volt);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {volt, cur};
        do
            @(posedge i_clk);
        while (!s_axis_tready);
        plateau_expect_q.push_back(predict_plateau(op, cur, volt));
    endtask

    // Stop sending and let every outstanding result come back.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (plateau_expect_q.size() != 0)
            @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        case (idx)
            REG_CLAMP_LIMIT:   cfg_clamp  = val[CLAMP_W-1:0];
            REG_SETTLE_WINDOW: cfg_window = val[WIN_W-1:0];
            REG_HOLD_COUNT:    cfg_hold   = val[HOLD_W-1:0];
            REG_FULL_VOLTAGE:  cfg_fullv  = val[VOLT_W-1:0];
            default: ;
        endcase
    endtask

    // Registers change only with the pipeline empty.
    task automatic program_regs(logic [15:0] clamp, logic [15:0] window,
                                logic [15:0] hold, logic [15:0] fullv);
        drain_results();
        write_reg(REG_CLAMP_LIMIT, clamp);
        write_reg(REG_SETTLE_WINDOW, window);
        write_reg(REG_HOLD_COUNT, hold);
        write_reg(REG_FULL_VOLTAGE, fullv);
        i_cfg_we <= 1'b0;
    endtask

    // Reset defaults: first sample after reset, clamp in both directions,
    // current and voltage extremes, voltage around the full threshold.
    task automatic test_reset_defaults();
        send_item(OP_SAMPLE, 24'd1000, 16'd28800);
        send_item(OP_SAMPLE, 24'h7FFFFF, 16'd65535);
        send_item(OP_SAMPLE, 24'h800000, 16'd0);
        send_item(OP_SAMPLE, 24'hFFFFFF, 16'd28799);
        send_item(OP_SAMPLE, 24'h000000, 16'd28800);
        send_item(OP_SAMPLE, 24'h000000, 16'hAAAA);
        send_item(OP_SAMPLE, 24'h555555, 16'h5555);
        send_item(OP_SAMPLE, 24'hAAAAAA, 16'hFFFF);
    endtask

    // Clear drops all state; the next sample differentiates against zero.
    task automatic test_clear_operation();
        send_item(OP_CLEAR, 24'hFFFFFF, 16'hFFFF);
        send_item(OP_SAMPLE, -24'sd1500, 16'd30000);
        send_item(OP_SAMPLE, -24'sd1500, 16'd30000);
        send_item(OP_CLEAR, 24'h000000, 16'h0000);
        send_item(OP_SAMPLE, 24'd7, 16'd100);
    endtask

    // Register extremes, including write data wider than the register.
    task automatic test_register_extremes();
        program_regs(16'd0, 16'd0, 16'd0, 16'd0);
        send_item(OP_SAMPLE, 24'h7FFFFF, 16'd0);       // zero clamp: no slope at all
        send_item(OP_SAMPLE, 24'h800000, 16'd1);
        send_item(OP_SAMPLE, 24'h123456, 16'd65535);
        program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_item(OP_SAMPLE, 24'h800000, 16'd65535);
        send_item(OP_SAMPLE, 24'h7FFFFF, 16'd65535);
        send_item(OP_SAMPLE, 24'h800000, 16'd65534);
        send_item(OP_SAMPLE, 24'h7FFFFF, 16'd65535);
        program_regs(16'd32767, 16'd0, 16'd0, 16'd65535);
        send_item(OP_CLEAR, 24'h0, 16'h0);
        send_item(OP_SAMPLE, 24'd0, 16'd65535);        // settled, full at top voltage
        send_item(OP_SAMPLE, 24'd0, 16'd65535);
        send_item(OP_SAMPLE, 24'd0, 16'd65534);
    endtask

    function automatic logic [15:0] near_threshold();
        int v;
        v = int'(cfg_fullv) + int'($urandom_range(0, 40)) - 10;
        if (v < 0)
            v = 0;
        if (v > 65535)
            v = 65535;
        return v[15:0];
    endfunction

    // Random mix: mostly plateau runs (often after a clear) with small
    // current jitter and voltage near the threshold, plus noise and clears.
    // The registers are redrawn every hundred items.
    task automatic test_random_plateaus(int unsigned n_items);
        int unsigned sent, next_cfg, run_len, pick, jit, k;
        int base, cur;
        logic [15:0] clamp, window, hold, fullv;
        sent = 0;
        next_cfg = 0;
        while (sent < n_items) begin
            if (sent >= next_cfg) begin
                clamp  = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3000));
                window = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
                hold   = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 30));
                fullv  = ($urandom_range(3) == 0) ? 16'($urandom)
                                                  : 16'($urandom_range(20000, 30000));
                program_regs(clamp, window, hold, fullv);
                next_cfg = sent + 100;
            end
            pick = $urandom_range(99);
            if (pick < 5) begin
                send_item(OP_CLEAR, 24'($urandom), 16'($urandom));
                sent++;
            end else if (pick < 25) begin
                send_item(OP_SAMPLE, 24'($urandom), 16'($urandom));
                sent++;
            end else begin
                if ($urandom_range(9) < 7) begin
                    send_item(OP_CLEAR, 24'($urandom), 16'($urandom));
                    sent++;
                    base = int'($urandom_range(0, 200)) - 100;
                end else begin
                    base = $signed(24'($urandom));
                end
                run_len = $urandom_range(10, 60);
                jit = $urandom_range(0, 3);
                for (k = 0; k < run_len; k++) begin
                    cur = base + int'($urandom_range(0, 2 * jit)) - int'(jit);
                    send_item(OP_SAMPLE, cur[23:0], near_threshold());
                end
                sent += run_len;
            end
        end
    endtask

    // Long settled runs: the full flag must rise once the counter passes
    // a small hold count, and never rise with the hold count at its top.
    task automatic test_hold_boundary();
        int k, cur;
        program_regs(16'd2000, 16'hFFFF, 16'd20, 16'd0);
        send_item(OP_CLEAR, 24'h0, 16'h0);
        for (k = 0; k < 30; k++) begin
            cur = int'($urandom_range(0, 100)) - 50;
            send_item(OP_SAMPLE, cur[23:0], 16'($urandom));
        end
        program_regs(16'd2000, 16'd1023, 16'd65535, 16'd0);
        for (k = 0; k < 4; k++)
            send_item(OP_SAMPLE, 24'd0, 16'($urandom));
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // sender idles 17 %, receiver 57 %
        src_idle_pct  = 17;
        sink_idle_pct = 57;
        test_reset_defaults();
        test_clear_operation();
        test_register_extremes();
        test_random_plateaus(270);

        // sides swapped
        drain_results();
        src_idle_pct  = 57;
        sink_idle_pct = 17;
        test_random_plateaus(270);

        // full rate on both sides
        drain_results();
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        test_random_plateaus(270);
        test_hold_boundary();

        drain_results();
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/ccpd_pkg.sv
rtl/core/charge_current_plateau_detector_unit.sv
test/tb.sv
